### sv/htw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_pkg: shared definitions of the hashed timing wheel
// Field widths, operation and status codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int TIMERS_DEF  = 16;
  localparam int MAX_RESULTS = 16;

  localparam int FUNC_W     = 2;
  localparam int TIMEOUT_W  = 32;
  localparam int HANDLE_W   = 4;
  localparam int STATUS_W   = 3;
  localparam int IVL_W      = 16;
  localparam int SLOTS_W    = 9;
  localparam int SLOT_W     = 8;
  localparam int ROT_W      = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_W      = 32;
  localparam int DVSR_W     = 16;
  localparam int EXP_CNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD  = 2'd0,
    FN_DEL  = 2'd1,
    FN_TICK = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_NEG      = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_DEL_FREE = 3'd4,
    ST_EXPIRED  = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_INTERVAL = 1'd0,
    CFG_SLOT_COUNT    = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_TICKS = 2'd0,
    DIV_SLOTS = 2'd1,
    DIV_WRAP  = 2'd2,
    DIV_ADV   = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    div_sel_t div_sel;
    logic     emit;
    status_t  emit_status;
    logic     scan_clear;
    logic     scan_step;
    logic     adv_slot;
  } htw_cmd_t;

  typedef struct packed {
    func_t func;
    logic  neg;
    logic  full;
    logic  del_hit;
    logic  div_busy;
    logic  out_free;
    logic  scan_exp;
    logic  scan_last;
    logic  pend_valid;
  } htw_stat_t;

endpackage

### sv/htw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_if: channel interfaces of the hashed timing wheel
// Request channel (operation items) and result channel, each with valid,
// ready and payload.
// ----------------------------------------------------------------------------
interface htw_in_if;
  import htw_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [FUNC_W-1:0]           func;
  logic signed [TIMEOUT_W-1:0] timeout;
  logic [HANDLE_W-1:0]         handle_in;

  modport source (output valid, func, timeout, handle_in, input ready);
  modport sink   (input valid, func, timeout, handle_in, output ready);
endinterface

interface htw_out_if;
  import htw_pkg::*;

  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] handle_out;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, handle_out, status, last, input ready);
  modport sink   (input valid, handle_out, status, last, output ready);
endinterface

### sv/htw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_div: restoring divider
// Unsigned division, one quotient bit per cycle. Results hold until the
// next start.
// ----------------------------------------------------------------------------
module htw_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [htw_pkg::DIV_W-1:0]   dividend,
  input  logic [htw_pkg::DVSR_W-1:0]  divisor,
  output logic                        busy,
  output logic [htw_pkg::DIV_W-1:0]   quotient,
  output logic [htw_pkg::DVSR_W-1:0]  remainder
);
  import htw_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DVSR_W-1:0] rem_r;
  logic [DVSR_W-1:0] dvsr_r;
  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    diff  = trial - {1'b0, dvsr_r};
    ge    = (trial >= {1'b0, dvsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIV_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
    end
  end

  assign busy      = (cnt_r != '0);
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### sv/htw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_dp: datapath of the hashed timing wheel
// Configuration registers, timer entry store, scan pointer, shared divider
// and the result register.
// ----------------------------------------------------------------------------
module htw_dp #(
  parameter int TIMERS = htw_pkg::TIMERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  htw_pkg::htw_cmd_t               cmd,
  output htw_pkg::htw_stat_t              stat,
  input  logic [htw_pkg::FUNC_W-1:0]      in_func,
  input  logic signed [htw_pkg::TIMEOUT_W-1:0] in_timeout,
  input  logic [htw_pkg::HANDLE_W-1:0]    in_handle,
  input  logic                            cfg_we,
  input  logic [htw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [htw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [htw_pkg::HANDLE_W-1:0]    out_handle,
  output logic [htw_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_last
);
  import htw_pkg::*;

  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  // Configuration
  logic [IVL_W-1:0]   ivl_r;
  logic [SLOTS_W-1:0] slots_r;
  logic [IVL_W-1:0]   eff_iv;
  logic [SLOTS_W-1:0] eff_n;

  // Captured item
  func_t                  op_func_r;
  logic [TIMEOUT_W-1:0]   op_timeout_r;
  logic [HANDLE_W-1:0]    op_handle_r;

  // Entry store
  logic [TIMERS-1:0]      ent_valid_r;
  logic [SLOT_W-1:0]      ent_slot_r [TIMERS];
  logic [ROT_W-1:0]       ent_rot_r  [TIMERS];
  logic [SLOT_W-1:0]      cur_r;
  logic [ROT_W-1:0]       rot_r;

  // Tick scan
  logic [IW-1:0]          scan_idx_r;
  logic [EXP_CNT_W-1:0]   exp_cnt_r;
  logic                   pend_valid_r;
  logic [IW-1:0]          pend_idx_r;

  // Result register
  logic                   out_valid_r;
  logic [HANDLE_W-1:0]    out_handle_r;
  status_t                out_status_r;
  logic                   out_last_r;

  // Divider
  logic [DIV_W-1:0]       div_dvd;
  logic [DVSR_W-1:0]      div_dvsr;
  logic                   div_busy;
  logic [DIV_W-1:0]       div_quo;
  logic [DVSR_W-1:0]      div_rem;
  logic [DIV_W-1:0]       ticks;
  logic [SLOTS_W-1:0]     wrap_sum;
  logic [SLOTS_W-1:0]     adv_sum;

  logic [IW-1:0]          free_idx;
  logic [IW-1:0]          del_idx;
  logic                   del_hit;
  logic                   sc_hit;
  logic                   sc_exp;
  logic                   sc_dec;
  logic                   out_free;
  logic                   scan_emit;
  logic                   add_commit;
  logic                   del_commit;

  always_comb begin
    eff_iv = (ivl_r == '0) ? IVL_W'(1) : ivl_r;
    if (slots_r == '0) begin
      eff_n = SLOTS_W'(1);
    end else if (slots_r > SLOTS_W'(256)) begin
      eff_n = SLOTS_W'(256);
    end else begin
      eff_n = slots_r;
    end
  end

  // Lowest free entry.
  always_comb begin
    free_idx = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!ent_valid_r[i]) free_idx = IW'(i);
    end
  end

  always_comb begin
    del_idx = IW'(op_handle_r);
    del_hit = (int'(op_handle_r) < TIMERS) && ent_valid_r[del_idx];
  end

  always_comb begin
    sc_hit = ent_valid_r[scan_idx_r] && (ent_slot_r[scan_idx_r] == cur_r);
    sc_dec = sc_hit && (ent_rot_r[scan_idx_r] != '0);
    sc_exp = sc_hit && (ent_rot_r[scan_idx_r] == '0) &&
             (exp_cnt_r != EXP_CNT_W'(MAX_RESULTS));
  end

  // A quotient of zero means the timeout is below one interval: one tick.
  always_comb begin
    ticks    = (div_quo == '0) ? DIV_W'(1) : div_quo;
    wrap_sum = {1'b0, cur_r} + div_rem[SLOTS_W-1:0];
    adv_sum  = {1'b0, cur_r} + SLOTS_W'(1);
    div_dvsr = {{(DVSR_W - SLOTS_W){1'b0}}, eff_n};
    div_dvd  = '0;
    case (cmd.div_sel)
      DIV_TICKS: begin
        div_dvd  = {1'b0, op_timeout_r[TIMEOUT_W-2:0]};
        div_dvsr = eff_iv;
      end
      DIV_SLOTS: div_dvd = ticks;
      DIV_WRAP:  div_dvd = DIV_W'(wrap_sum);
      DIV_ADV:   div_dvd = DIV_W'(adv_sum);
      default:   div_dvd = '0;
    endcase
  end

  htw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvsr),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_free   = !out_valid_r || out_ready;
  assign scan_emit  = cmd.scan_step && sc_exp && pend_valid_r;
  assign add_commit = cmd.emit && (cmd.emit_status == ST_ADDED);
  assign del_commit = cmd.emit && (cmd.emit_status == ST_DELETED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivl_r   <= IVL_W'(1);
      slots_r <= SLOTS_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TICK_INTERVAL: ivl_r   <= cfg_wdata;
        CFG_SLOT_COUNT:    slots_r <= cfg_wdata[SLOTS_W-1:0];
        default:           ivl_r   <= ivl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func_r    <= func_t'(in_func);
      op_timeout_r <= in_timeout;
      op_handle_r  <= in_handle;
    end
    if (cmd.div_start && (cmd.div_sel == DIV_WRAP)) begin
      rot_r <= div_quo[ROT_W-1:0];
    end
    if (add_commit) begin
      ent_slot_r[free_idx] <= div_rem[SLOT_W-1:0];
      ent_rot_r[free_idx]  <= rot_r;
    end
    if (cmd.scan_step && sc_dec) begin
      ent_rot_r[scan_idx_r] <= ent_rot_r[scan_idx_r] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
      cur_r       <= '0;
    end else begin
      if (add_commit) ent_valid_r[free_idx] <= 1'b1;
      if (del_commit) ent_valid_r[del_idx] <= 1'b0;
      if (cmd.scan_step && sc_exp) ent_valid_r[scan_idx_r] <= 1'b0;
      if (cmd.adv_slot) cur_r <= div_rem[SLOT_W-1:0];
    end
  end

  // Each expiry is held back until the next one is found, so that the last
  // result of a tick can be marked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      exp_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.scan_clear) begin
      scan_idx_r   <= '0;
      exp_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (sc_exp) begin
        exp_cnt_r    <= exp_cnt_r + 1'b1;
        pend_valid_r <= 1'b1;
      end
    end else if (cmd.emit && (cmd.emit_status == ST_EXPIRED)) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && sc_exp) pend_idx_r <= scan_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || scan_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_last_r   <= 1'b1;
      case (cmd.emit_status)
        ST_ADDED:                out_handle_r <= HANDLE_W'(free_idx);
        ST_DELETED, ST_DEL_FREE: out_handle_r <= op_handle_r;
        ST_EXPIRED:              out_handle_r <= HANDLE_W'(pend_idx_r);
        default:                 out_handle_r <= '0;
      endcase
    end else if (scan_emit) begin
      out_status_r <= ST_EXPIRED;
      out_last_r   <= 1'b0;
      out_handle_r <= HANDLE_W'(pend_idx_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_handle = out_handle_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  always_comb begin
    stat            = '0;
    stat.func       = op_func_r;
    stat.neg        = op_timeout_r[TIMEOUT_W-1];
    stat.full       = &ent_valid_r;
    stat.del_hit    = del_hit;
    stat.div_busy   = div_busy;
    stat.out_free   = out_free;
    stat.scan_exp   = sc_exp;
    stat.scan_last  = (scan_idx_r == IW'(TIMERS - 1));
    stat.pend_valid = pend_valid_r;
  end

endmodule

### sv/htw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_ctrl: controller of the hashed timing wheel
// Sequences each operation: decode, divider passes for an add, the entry
// scan and slot advance of a tick, and the hand-off of results to the result register.
// ----------------------------------------------------------------------------
module htw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  htw_pkg::htw_stat_t  stat,
  output htw_pkg::htw_cmd_t   cmd
);
  import htw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_T,
    S_DIV_S,
    S_DIV_W,
    S_EMIT,
    S_SCAN,
    S_SCAN_END,
    S_ADV
  } state_t;

  state_t  state_r, state_nxt;
  status_t em_st_r, em_st_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    em_st_nxt = em_st_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.func)
          FN_ADD: begin
            if (stat.neg) begin
              em_st_nxt = ST_NEG;
              state_nxt = S_EMIT;
            end else if (stat.full) begin
              em_st_nxt = ST_FULL;
              state_nxt = S_EMIT;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = DIV_TICKS;
              state_nxt     = S_DIV_T;
            end
          end
          FN_DEL: begin
            em_st_nxt = stat.del_hit ? ST_DELETED : ST_DEL_FREE;
            state_nxt = S_EMIT;
          end
          FN_TICK: begin
            cmd.scan_clear = 1'b1;
            state_nxt      = S_SCAN;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV_T: begin
        if (!stat.div_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SLOTS;
          state_nxt     = S_DIV_S;
        end
      end
      S_DIV_S: begin
        if (!stat.div_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_WRAP;
          state_nxt     = S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (!stat.div_busy) begin
          em_st_nxt = ST_ADDED;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = em_st_r;
          state_nxt       = S_IDLE;
        end
      end
      S_SCAN: begin
        // A new expiry pushes the held one out, which needs a free result slot.
        if (!(stat.scan_exp && stat.pend_valid && !stat.out_free)) begin
          cmd.scan_step = 1'b1;
          if (stat.scan_last) state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        if (!stat.pend_valid || stat.out_free) begin
          cmd.emit        = stat.pend_valid;
          cmd.emit_status = ST_EXPIRED;
          cmd.div_start   = 1'b1;
          cmd.div_sel     = DIV_ADV;
          state_nxt       = S_ADV;
        end
      end
      S_ADV: begin
        if (!stat.div_busy) begin
          cmd.adv_slot = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      em_st_r <= ST_ADDED;
    end else begin
      state_r <= state_nxt;
      em_st_r <= em_st_nxt;
    end
  end

endmodule

### sv/hashed_timing_wheel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_timing_wheel: timer wheel over a fixed pool of timer entries
// Adds, deletes and expires timers; results report each outcome.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in_ch   | in        | valid / ready       | func, timeout, handle_in
//  out_ch  | out       | valid / ready       | handle_out, status, last
//  cfg     | in        | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// One item at a time. An add runs three 32-step passes of the shared
// divider; a tick scans one entry per cycle unless a stalled result
// register holds it, then runs one divider pass to advance the slot; a
// delete runs no divider pass. Reset frees every entry through its valid bit.
// A stalled result register holds the block at its next result; the next
// item is accepted while the last result of the previous one still waits.
// ----------------------------------------------------------------------------
module hashed_timing_wheel #(
  parameter int TIMERS = htw_pkg::TIMERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  htw_in_if.sink                         in_ch,
  htw_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [htw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import htw_pkg::*;

  htw_cmd_t  cmd;
  htw_stat_t stat;

  htw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  htw_dp #(
    .TIMERS (TIMERS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (in_ch.func),
    .in_timeout (in_ch.timeout),
    .in_handle  (in_ch.handle_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_handle (out_ch.handle_out),
    .out_status (out_ch.status),
    .out_last   (out_ch.last)
  );

endmodule

### sv/htw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_checker: port-level checks of the hashed timing wheel
// Watches the channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module htw_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [htw_pkg::HANDLE_W-1:0]   out_handle,
  input logic [htw_pkg::STATUS_W-1:0]   out_status,
  input logic                           out_last
);
  import htw_pkg::*;

  // Every item passes through decode before the next one is taken.
  a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request ready stayed high after an accepted item");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_EXPIRED)
    else $error("result status out of range");

  // Only expiries come in groups; every other result closes its item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_EXPIRED |-> out_last)
    else $error("add or delete result not marked last");

  a_reject_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NEG || out_status == ST_FULL) |-> out_handle == '0)
    else $error("rejected add reports a nonzero handle");

endmodule

bind hashed_timing_wheel htw_checker u_htw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_handle (out_ch.handle_out),
  .out_status (out_ch.status),
  .out_last   (out_ch.last)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking regression of the hashed timing wheel
// Drives add, delete and tick items into the wheel under bursty input and a
// stalling result side. A scoreboard keeps its own copy of the timer pool and
// wheel position, predicts the result items of every accepted item and checks
// each returned result against them. The run steps through several register
// settings, the extremes among them, and ends with a pass or fail line.
// ----------------------------------------------------------------------------
module tb;
  import htw_pkg::*;

  localparam int TIMERS           = TIMERS_DEF;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 24;
  localparam int SETTLE_CYCLES    = 200;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT      = 400000;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    status_t             status;
    logic                last;
  } wheel_result_t;

  class wheel_scoreboard;
    logic [IVL_W-1:0]   interval_reg;
    logic [SLOTS_W-1:0] slots_reg;
    bit                 entry_busy [TIMERS];
    int unsigned        entry_slot [TIMERS];
    int unsigned        entry_turns[TIMERS];
    int unsigned        wheel_pos;
    wheel_result_t      due_results[$];
    int                 fails, checked, expiries, refusals, adds, deletes, ticks;

    function new();
      interval_reg = 1;
      slots_reg    = 8;
      wheel_pos    = 0;
      foreach (entry_busy[i]) begin
        entry_busy[i]  = 1'b0;
        entry_slot[i]  = 0;
        entry_turns[i] = 0;
      end
      fails    = 0;
      checked  = 0;
      expiries = 0;
      refusals = 0;
      adds     = 0;
      deletes  = 0;
      ticks    = 0;
    endfunction

    function int unsigned wheel_interval();
      return (interval_reg == 0) ? 1 : interval_reg;
    endfunction

    function int unsigned wheel_slots();
      if (slots_reg == 0) return 1;
      if (slots_reg > 256) return 256;
      return slots_reg;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_TICK_INTERVAL: interval_reg = value[IVL_W-1:0];
        CFG_SLOT_COUNT:    slots_reg    = value[SLOTS_W-1:0];
        default: ;
      endcase
    endfunction

    function void expect_result(int unsigned h, status_t st, logic l);
      wheel_result_t r;
      r.handle = h[HANDLE_W-1:0];
      r.status = st;
      r.last   = l;
      due_results.push_back(r);
    endfunction

    // Works out the result items of one accepted item and moves the pool on.
    function void note_input(logic [FUNC_W-1:0] f, logic [TIMEOUT_W-1:0] t,
                             logic [HANDLE_W-1:0] h);
      int unsigned iv, n, span, free_idx;
      int unsigned fired[$];
      iv = wheel_interval();
      n  = wheel_slots();
      case (func_t'(f))
        FN_ADD: begin
          adds++;
          if (t[TIMEOUT_W-1]) begin
            expect_result(0, ST_NEG, 1'b1);
          end else begin
            span = (t < iv) ? 1 : t / iv;
            free_idx = TIMERS;
            for (int i = TIMERS - 1; i >= 0; i--) if (!entry_busy[i]) free_idx = i;
            if (free_idx == TIMERS) begin
              refusals++;
              expect_result(0, ST_FULL, 1'b1);
            end else begin
              entry_busy[free_idx]  = 1'b1;
              entry_turns[free_idx] = span / n;
              entry_slot[free_idx]  = (wheel_pos + span % n) % n;
              expect_result(free_idx, ST_ADDED, 1'b1);
            end
          end
        end
        FN_DEL: begin
          deletes++;
          if (h < TIMERS && entry_busy[h]) begin
            entry_busy[h] = 1'b0;
            expect_result(h, ST_DELETED, 1'b1);
          end else begin
            expect_result(h, ST_DEL_FREE, 1'b1);
          end
        end
        FN_TICK: begin
          ticks++;
          for (int i = 0; i < TIMERS; i++) begin
            if (!entry_busy[i] || entry_slot[i] != wheel_pos) continue;
            if (entry_turns[i] > 0) begin
              entry_turns[i]--;
            end else if (fired.size() < MAX_RESULTS) begin
              entry_busy[i] = 1'b0;
              fired.push_back(i);
            end
          end
          foreach (fired[k]) expect_result(fired[k], ST_EXPIRED, k == fired.size() - 1);
          expiries += fired.size();
          wheel_pos = (wheel_pos + 1) % n;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [HANDLE_W-1:0] h, logic [STATUS_W-1:0] st, logic l);
      wheel_result_t exp_r;
      if (due_results.size() == 0) begin
        $error("unexpected result item: handle_out %0d status %0d last %0b", h, st, l);
        fails++;
        return;
      end
      exp_r = due_results.pop_front();
      checked++;
      if (h !== exp_r.handle) begin
        $error("handle_out: expected %0d, got %0d", exp_r.handle, h);
        fails++;
      end
      if (st !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, st);
        fails++;
      end
      if (l !== exp_r.last) begin
        $error("last: expected %0b, got %0b", exp_r.last, l);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  htw_in_if  in_ch ();
  htw_out_if out_ch ();

  hashed_timing_wheel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  wheel_scoreboard sb;
  logic            want_long_hold;
  int              burst_left;
  int              cycle_count;

  logic [CFG_DATA_W-1:0] phase_interval [PHASES] =
    '{16'd3, 16'd65535, 16'd0, 16'd2, 16'd1, 16'd7};
  // The third setting carries junk above the nine slot-count bits.
  logic [CFG_DATA_W-1:0] phase_slots [PHASES] =
    '{16'd16, 16'd256, 16'hFE04, 16'd0, 16'd511, 16'd5};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic idle_sender(input int cycles);
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_W'($urandom_range(0, 3));
    in_ch.timeout   <= $urandom();
    in_ch.handle_in <= HANDLE_W'($urandom_range(0, TIMERS - 1));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic offer_item(input func_t f, input logic [TIMEOUT_W-1:0] t,
                            input logic [HANDLE_W-1:0] h);
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.timeout   <= t;
    in_ch.handle_in <= h;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(f, t, h);
    // Bursts of back-to-back items, then a gap.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_sender($urandom_range(1, 8));
      burst_left = $urandom_range(0, 11);
    end
  endtask

  task automatic offer_random_item();
    int unsigned iv, n, near, roll;
    logic [TIMEOUT_W-1:0] t;
    logic [HANDLE_W-1:0]  h;
    func_t                f;
    int unsigned          busy[$];
    iv   = sb.wheel_interval();
    n    = sb.wheel_slots();
    near = iv * ((n < 8) ? n : 8) * 2;
    t    = $urandom();
    h    = HANDLE_W'($urandom_range(0, TIMERS - 1));
    roll = $urandom_range(0, 99);
    if (roll < 36) begin
      f    = FN_ADD;
      roll = $urandom_range(0, 99);
      if (roll < 10)      t = $urandom();
      else if (roll < 15) t = 32'd0 - $urandom_range(1, 1000);
      else if (roll < 25) t = $urandom_range(0, iv - 1);
      else if (roll < 80) t = $urandom_range(0, near);
      else                t = $urandom_range(0, iv * n * 3);
    end else if (roll < 56) begin
      f = FN_DEL;
      foreach (sb.entry_busy[i]) if (sb.entry_busy[i]) busy.push_back(i);
      if (busy.size() > 0 && $urandom_range(0, 4) != 0)
        h = HANDLE_W'(busy[$urandom_range(0, busy.size() - 1)]);
    end else if (roll < 96) begin
      f = FN_TICK;
    end else begin
      f = FN_NOP;
    end
    offer_item(f, t, h);
  endtask

  // Waits for every outstanding result, then lets a silent tick finish.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] iv,
                               input logic [CFG_DATA_W-1:0] slots);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TICK_INTERVAL;
    cfg_wdata <= iv;
    @(posedge clk);
    sb.write_reg(CFG_TICK_INTERVAL, iv);
    cfg_index <= CFG_SLOT_COUNT;
    cfg_wdata <= slots;
    @(posedge clk);
    sb.write_reg(CFG_SLOT_COUNT, slots);
    cfg_we <= 1'b0;
  endtask

  // Result side: checks each accepted result and stalls on its own pattern.
  initial begin
    int mode, mode_left, hold_left;
    bit long_hold_done;
    mode           = 0;
    mode_left      = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    out_ch.ready   = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.handle_out, out_ch.status, out_ch.last);
      if (want_long_hold && !long_hold_done) begin
        hold_left      = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("hashed_timing_wheel regression: fail");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_TICK_INTERVAL;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FN_NOP;
    in_ch.timeout   = '0;
    in_ch.handle_in = '0;
    want_long_hold  = 1'b0;
    burst_left      = 0;
    sb              = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: interval 1, eight slots.
    offer_item(FN_ADD, 32'd0, 4'd0);            // below one interval: one tick
    offer_item(FN_ADD, 32'hFFFF_FFFF, 4'd0);    // negative timeouts are refused
    offer_item(FN_ADD, 32'h8000_0000, 4'd15);
    offer_item(FN_ADD, 32'h7FFF_FFFF, 4'd9);    // huge rotation count
    offer_item(FN_DEL, 32'd0, 4'd15);           // delete of a free entry
    offer_item(FN_DEL, 32'hFFFF_FFFF, 4'd1);
    offer_item(FN_NOP, 32'h5A5A_A5A5, 4'd6);
    offer_item(FN_TICK, 32'd0, 4'd0);           // empty slot, no result
    offer_item(FN_TICK, 32'd0, 4'd0);           // first timer expires
    // Fill the pool into one slot, overflow it, then fire all sixteen at once.
    repeat (TIMERS) offer_item(FN_ADD, 32'd1, 4'd0);
    offer_item(FN_ADD, 32'd3, 4'd0);
    offer_item(FN_TICK, 32'd0, 4'd0);
    offer_item(FN_TICK, 32'd0, 4'd0);

    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      load_settings(phase_interval[p], phase_slots[p]);
      // Stall the result side for a long stretch so that the wheel backs up.
      if (p == 1) want_long_hold = 1'b1;
      repeat (RANDOM_PER_PHASE) offer_random_item();
    end
    settle_block();

    $display("Covered %0d adds, %0d deletes and %0d ticks over %0d register settings;",
             sb.adds, sb.deletes, sb.ticks, PHASES + 1);
    $display("checked %0d results, among them %0d expiries and %0d pool-full refusals.",
             sb.checked, sb.expiries, sb.refusals);
    if (sb.fails == 0 && sb.due_results.size() == 0) begin
      $display("hashed_timing_wheel regression: pass");
    end else begin
      $display("hashed_timing_wheel regression: fail");
    end
    $finish;
  end
endmodule

### sim.f
sv/htw_pkg.sv
sv/htw_if.sv
sv/htw_div.sv
sv/htw_dp.sv
sv/htw_ctrl.sv
sv/hashed_timing_wheel.sv
sv/htw_checker.sv
bench/tb.sv
